// ----- rtl/core/cpra_pkg.sv -----
// ----------------------------------------------------------------------------
// cpra_pkg
// Shared types, sizes and helpers for the contiguous page run allocator.
// ----------------------------------------------------------------------------
package cpra_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int PAGE_BYTES    = 4096;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int IDX_W      = $clog2(TABLE_ENTRIES);
  localparam int CNT_W      = $clog2(TABLE_ENTRIES + 1);

  localparam int ADDR_W  = 48;
  localparam int PAGES_W = 36;
  localparam int TYPE_W  = 4;
  localparam int TOTAL_W = 54;
  localparam int ACC_W   = TOTAL_W - PAGE_SHIFT;
  localparam int HAVE_W  = PAGES_W + 1;

  localparam logic [0:0] MODE_WRITE = 1'b0;
  localparam logic [0:0] MODE_ALLOC = 1'b1;

  typedef struct packed {
    logic [0:0]         mode;
    logic [5:0]         entry_index;
    logic [TYPE_W-1:0]  entry_type;
    logic [ADDR_W-1:0]  entry_start;
    logic [PAGES_W-1:0] entry_pages;
    logic [PAGES_W-1:0] request_pages;
  } item_t;

  typedef struct packed {
    logic [0:0]         granted;
    logic [ADDR_W-1:0]  grant_address;
    logic [TOTAL_W-1:0] total_bytes;
  } result_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  rtype;
    logic [ADDR_W-1:0]  start;
    logic [PAGES_W-1:0] pages;
  } desc_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_WRITE, S_FWD_RD, S_FWD_EV,
    S_BWD_RD, S_BWD_EV, S_SUM_RD, S_SUM_EV, S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic tbl_write;
    logic rd;
    logic fwd_init;
    logic fwd_eval;
    logic bwd_init;
    logic bwd_eval;
    logic sum_init;
    logic sum_eval;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic want_zero;
    logic scan_end;
    logic run_full;
    logic bwd_stop;
  } status_t;

  // End byte address of a region, wrapping at the address width.
  function automatic logic [ADDR_W-1:0] region_end(input logic [ADDR_W-1:0] start,
                                                    input logic [PAGES_W-1:0] pages);
    logic [63:0] span;
    span = 64'(pages) << PAGE_SHIFT;
    return start + span[ADDR_W-1:0];
  endfunction

endpackage

// ----- rtl/core/cpra_ctrl.sv -----
// ----------------------------------------------------------------------------
// cpra_ctrl
// Sequencer: dispatch, forward run scan, backward take, table total sweep.
// ----------------------------------------------------------------------------
module cpra_ctrl import cpra_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  output logic    done,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.mode == MODE_WRITE) begin
          state_next = S_WRITE;
        end else if (status.want_zero) begin
          cmd.sum_init = 1'b1;
          state_next   = S_SUM_RD;
        end else begin
          cmd.fwd_init = 1'b1;
          state_next   = S_FWD_RD;
        end
      end
      S_WRITE: begin
        cmd.tbl_write = 1'b1;
        cmd.sum_init  = 1'b1;
        state_next    = S_SUM_RD;
      end
      S_FWD_RD: begin
        if (status.run_full) begin
          cmd.bwd_init = 1'b1;
          state_next   = S_BWD_RD;
        end else if (status.scan_end) begin
          cmd.sum_init = 1'b1;
          state_next   = S_SUM_RD;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_FWD_EV;
        end
      end
      S_FWD_EV: begin
        cmd.fwd_eval = 1'b1;
        state_next   = S_FWD_RD;
      end
      S_BWD_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_BWD_EV;
      end
      S_BWD_EV: begin
        cmd.bwd_eval = 1'b1;
        if (status.bwd_stop) begin
          cmd.sum_init = 1'b1;
          state_next   = S_SUM_RD;
        end else begin
          state_next = S_BWD_RD;
        end
      end
      S_SUM_RD: begin
        if (status.scan_end) begin
          state_next = S_DONE;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_SUM_EV;
        end
      end
      S_SUM_EV: begin
        cmd.sum_eval = 1'b1;
        state_next   = S_SUM_RD;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// ----- rtl/core/cpra_dp.sv -----
// ----------------------------------------------------------------------------
// cpra_dp
// Descriptor table, scan registers, take arithmetic and byte total.
// ----------------------------------------------------------------------------
module cpra_dp import cpra_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  input  item_t      item,
  input  cmd_t       cmd,
  output status_t    status,
  output result_t    result
);

  desc_t                     mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]  valid;
  desc_t                     rd_raw;
  logic                      rd_valid;
  desc_t                     rd;

  logic [6:0]         entry_count;
  logic [CNT_W-1:0]   used;
  item_t              item_q;
  logic [CNT_W-1:0]   k;
  logic [HAVE_W-1:0]  have;
  logic [CNT_W-1:0]   first;
  logic [CNT_W-1:0]   last;
  logic [ADDR_W-1:0]  prev_end;
  logic [PAGES_W-1:0] left;
  logic [ACC_W-1:0]   acc;
  logic [0:0]         granted;
  logic [ADDR_W-1:0]  grant_address;

  logic               idx_ok;
  logic               usable;
  logic               brk;
  logic [PAGES_W-1:0] take;
  logic [PAGES_W-1:0] pages_left;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  desc_t              wr_data;

  always_ff @(posedge clk) begin
    if (rst) entry_count <= '0;
    else if (cfg_wr_en) entry_count <= cfg_wr_data;
  end

  assign used = (int'(entry_count) > TABLE_ENTRIES) ? CNT_W'(TABLE_ENTRIES)
                                                   : CNT_W'(entry_count);

  // unwritten slots read as the all-zero reset descriptor
  assign rd = rd_valid ? rd_raw : '0;

  assign idx_ok     = int'(item_q.entry_index) < TABLE_ENTRIES;
  assign usable     = (rd.rtype inside {[4'd1:4'd7]}) && (rd.pages != '0);
  assign brk        = !usable || ((k != first) && (prev_end != rd.start));
  assign take       = (rd.pages < left) ? rd.pages : left;
  assign pages_left = rd.pages - take;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = k[IDX_W-1:0];
    wr_data = '{rtype: rd.rtype, start: rd.start, pages: pages_left};
    if (cmd.tbl_write) begin
      wr_en   = idx_ok;
      wr_addr = IDX_W'(item_q.entry_index);
      wr_data = '{rtype: item_q.entry_type, start: item_q.entry_start,
                  pages: item_q.entry_pages};
    end else if (cmd.bwd_eval) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd) rd_raw <= mem[k[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) valid[wr_addr] <= 1'b1;
      if (cmd.rd) rd_valid <= valid[k[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q        <= item;
      granted       <= 1'b0;
      grant_address <= '1;
    end
    if (cmd.fwd_init) begin
      k     <= '0;
      have  <= '0;
      first <= '0;
      last  <= '0;
    end
    if (cmd.fwd_eval) begin
      k <= k + 1'b1;
      if (brk) begin
        have  <= '0;
        first <= k + 1'b1;
        last  <= k + 1'b1;
      end else begin
        have     <= have + HAVE_W'(rd.pages);
        last     <= k;
        prev_end <= region_end(rd.start, rd.pages);
      end
    end
    if (cmd.bwd_init) begin
      k    <= last;
      left <= item_q.request_pages;
    end
    if (cmd.bwd_eval) begin
      left <= left - take;
      if (status.bwd_stop) begin
        granted       <= 1'b1;
        grant_address <= region_end(rd.start, pages_left);
      end else begin
        k <= k - 1'b1;
      end
    end
    if (cmd.sum_init) begin
      k   <= '0;
      acc <= '0;
    end
    if (cmd.sum_eval) begin
      k   <= k + 1'b1;
      acc <= acc + ACC_W'(rd.pages);
    end
  end

  assign status.mode      = item_q.mode;
  assign status.want_zero = (item_q.request_pages == '0);
  assign status.scan_end  = (k == used);
  assign status.run_full  = (have >= HAVE_W'(item_q.request_pages));
  assign status.bwd_stop  = (left == take) || (k <= first);

  assign result.granted       = granted;
  assign result.grant_address = grant_address;
  assign result.total_bytes   = {acc, {PAGE_SHIFT{1'b0}}};

endmodule

// ----- rtl/core/contiguous_page_run_allocator.sv -----
// ----------------------------------------------------------------------------
// contiguous_page_run_allocator
// Descriptor table with a contiguous page run allocator and byte total.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive item and pulse start while busy is low; the word
//   is taken at that edge. mode 0 loads one descriptor, mode 1 allocates
//   request_pages pages from the first back-to-back usable run that holds enough.
//   Result channel: done is high for exactly one cycle with the result word;
//   the receiver must take it then, there is no backpressure.
//   Config: cfg_wr_en with cfg_wr_data sets entry_count; write only while
//   busy is low.
// Sequence (n = entries in use, at most the table size):
//   write item     : store the descriptor, then sweep the n entries.
//   allocate item  : forward scan over f entries, backward take from b
//                    entries, then sweep the n entries (zero-page request:
//                    sweep only).
//   Each table visit is a registered table read followed by an evaluate
//   step; the single-port descriptor table sets the rate.
//   The total is recomputed by a sweep over the table after every item.
// Reset: rst clears entry_count, the sequencer and the per-slot valid bits,
//   so every descriptor reads as zero until written. No clearing pass.
// ----------------------------------------------------------------------------
module contiguous_page_run_allocator import cpra_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  item_t      item,
  output logic       done,
  output result_t    result,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  cpra_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .cmd    (cmd)
  );

  // table, scan state and totals
  cpra_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .cmd         (cmd),
    .status      (status),
    .result      (result)
  );

endmodule

// ----- rtl/core/cpra_checker.sv -----
// ----------------------------------------------------------------------------
// cpra_checker
// Port-level checks on the allocator's command and result words.
// ----------------------------------------------------------------------------
module cpra_checker import cpra_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held longer than one cycle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result word while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");

  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    (done && !result.granted) |-> (result.grant_address == '1))
    else $error("failed word without all-ones address");

endmodule

bind contiguous_page_run_allocator cpra_checker u_cpra_checker (.*);

// ----- dv/tb_contiguous_page_run_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contiguous_page_run_allocator
// Drives descriptor writes and page allocations into the allocator, predicts
// each result word from a local copy of the descriptor table and entry count,
// and compares every result word field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_contiguous_page_run_allocator;
  import cpra_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  item_t      item = '0;
  logic       done;
  result_t    result;
  logic       cfg_wr_en = 1'b0;
  logic [6:0] cfg_wr_data = '0;

  contiguous_page_run_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the table
  logic [TYPE_W-1:0]  pred_type  [TABLE_ENTRIES];
  logic [ADDR_W-1:0]  pred_start [TABLE_ENTRIES];
  logic [PAGES_W-1:0] pred_pages [TABLE_ENTRIES];
  logic [6:0]         pred_count;

  item_t   pending_words[$];
  result_t expected_words[$];
  int      error_count = 0;
  bit      quiet_sender = 1'b0;  // no idle bursts near the end
  int      sender_gap = 0;

  function automatic logic [ADDR_W-1:0] span_end(int k);
    logic [63:0] bytes;
    bytes = 64'(pred_pages[k]) * PAGE_BYTES;
    return pred_start[k] + bytes[ADDR_W-1:0];
  endfunction

  function automatic int used_slots();
    return (pred_count > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(pred_count);
  endfunction

  function automatic bit slot_usable(int k);
    return pred_type[k] >= 1 && pred_type[k] <= 7 && pred_pages[k] != 0;
  endfunction

  // Forward scan for a back-to-back run, then take pages from its tail.
  function automatic bit carve_run(logic [PAGES_W-1:0] want, output logic [ADDR_W-1:0] addr);
    int n, first, last, k;
    logic [63:0] have, left, take;
    n = used_slots();
    have = 0; first = 0; last = 0;
    addr = '1;
    if (want == 0) return 1'b0;
    for (k = 0; k < n && have < want; k++) begin
      if (!slot_usable(k) || (k != first && span_end(last) != pred_start[k])) begin
        have = 0; first = k + 1; last = k + 1;
      end else begin
        have += pred_pages[k];
        last = k;
      end
    end
    if (have < want) return 1'b0;
    left = want;
    k = last;
    forever begin
      take = (pred_pages[k] < left) ? pred_pages[k] : left;
      pred_pages[k] -= take[PAGES_W-1:0];
      left -= take;
      if (left == 0 || k <= first) break;
      k--;
    end
    addr = span_end(k);
    return 1'b1;
  endfunction

  function automatic result_t predict_word(item_t w);
    result_t r;
    logic [63:0] sum;
    logic [ADDR_W-1:0] a;
    r.granted = 1'b0;
    r.grant_address = '1;
    if (w.mode == MODE_WRITE) begin
      pred_type[w.entry_index]  = w.entry_type;
      pred_start[w.entry_index] = w.entry_start;
      pred_pages[w.entry_index] = w.entry_pages;
    end else if (carve_run(w.request_pages, a)) begin
      r.granted = 1'b1;
      r.grant_address = a;
    end
    sum = 0;
    for (int k = 0; k < used_slots(); k++) sum += 64'(pred_pages[k]) * PAGE_BYTES;
    r.total_bytes = sum[TOTAL_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // driver: one word per accepted start, random idle bursts between words
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_words.push_back(predict_word(item));
      if (!quiet_sender && $urandom_range(0, 3) == 0) sender_gap = $urandom_range(1, 7);
      if (pending_words.size() > 0 && sender_gap == 0) item <= pending_words.pop_front();
      else start <= 1'b0;
    end else if (!start) begin
      if (sender_gap > 0) sender_gap--;
      else if (pending_words.size() > 0) begin
        item  <= pending_words.pop_front();
        start <= 1'b1;
      end
    end
  end

  // monitor: every done cycle carries one result word
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 64'(result), 64'd0);
      end else begin
        result_t e;
        e = expected_words.pop_front();
        if (result.granted !== e.granted)
          report_mismatch("granted", 64'(result.granted), 64'(e.granted));
        if (result.grant_address !== e.grant_address)
          report_mismatch("grant_address", 64'(result.grant_address), 64'(e.grant_address));
        if (result.total_bytes !== e.total_bytes)
          report_mismatch("total_bytes", 64'(result.total_bytes), 64'(e.total_bytes));
      end
    end
  end

  function automatic item_t write_word(int idx, int t, logic [47:0] s, logic [35:0] p);
    item_t w;
    w = '0;
    w.mode = MODE_WRITE; w.entry_index = 6'(idx); w.entry_type = 4'(t);
    w.entry_start = s; w.entry_pages = p;
    w.request_pages = 36'({$urandom, $urandom});
    return w;
  endfunction

  function automatic item_t alloc_word(logic [35:0] p);
    item_t w;
    w = {$urandom, $urandom, $urandom, $urandom, 3'($urandom)};
    w.mode = MODE_ALLOC;
    w.request_pages = p;
    return w;
  endfunction

  function automatic logic [35:0] rand_pages();
    case ($urandom_range(0, 5))
      0: return 36'({$urandom, $urandom});
      1: return '0;
      default: return 36'($urandom_range(1, 40));
    endcase
  endfunction

  // settle: wait for all results, then the block's worst latency
  task automatic drain();
    while (pending_words.size() > 0 || start || expected_words.size() > 0) @(posedge clk);
    repeat (450) @(posedge clk);
  endtask

  task automatic set_count(logic [6:0] c);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    pred_count = c;
  endtask

  // a chain of back-to-back regions with occasional breaks, then allocation requests mixed with random writes
  task automatic queue_phase(int slots, int words);
    logic [47:0] addr;
    int i, made;
    addr = 48'({$urandom, $urandom}) & ~48'hFFF;
    made = 0;
    for (i = 0; i < slots && made < words; i++, made++) begin
      logic [35:0] p;
      p = 36'($urandom_range(1, 12));
      if ($urandom_range(0, 9) == 0) p = '0;
      pending_words.push_back(write_word(i, ($urandom_range(0, 7) == 0) ?
        $urandom_range(8, 15) : $urandom_range(1, 7),
        ($urandom_range(0, 9) == 0) ? 48'({$urandom, $urandom}) : addr, p));
      addr += 48'(p) << 12;
    end
    for (; made < words; made++) begin
      if ($urandom_range(0, 4) == 0)
        pending_words.push_back(write_word($urandom_range(0, 63), $urandom_range(0, 15),
          48'({$urandom, $urandom}), rand_pages()));
      else pending_words.push_back(alloc_word(rand_pages()));
    end
  endtask

  initial begin
    int phase;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      pred_type[k] = '0; pred_start[k] = '0; pred_pages[k] = '0;
    end
    pred_count = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, wraparound, zero request, unusable types
    set_count(7'd64);
    pending_words.push_back(alloc_word(36'd1));
    pending_words.push_back(write_word(0, 1, 48'hFFFF_FFFF_F000, 36'd2));
    pending_words.push_back(write_word(1, 7, 48'h0000_0000_1000, 36'hF_FFFF_FFFF));
    pending_words.push_back(write_word(63, 15, '1, '1));
    pending_words.push_back(write_word(2, 0, 48'h0, 36'd5));
    pending_words.push_back(alloc_word(36'd0));
    pending_words.push_back(alloc_word(36'd3));
    pending_words.push_back(alloc_word('1));
    pending_words.push_back(alloc_word(36'd1));
    pending_words.push_back(write_word(3, 8, 48'h10_0000, 36'd4));
    pending_words.push_back(write_word(4, 3, 48'h10_4000, 36'd4));
    pending_words.push_back(alloc_word(36'd4));
    pending_words.push_back(alloc_word(36'd1));
    set_count(7'd127);
    pending_words.push_back(alloc_word(36'd2));
    pending_words.push_back(write_word(5, 2, 48'h0, 36'd0));
    set_count(7'd0);
    pending_words.push_back(alloc_word(36'd1));
    pending_words.push_back(write_word(6, 4, 48'h5000, 36'd9));

    // random phases, a new count before each
    for (phase = 0; phase < 24; phase++) begin
      logic [6:0] c;
      case (phase % 6)
        0: c = 7'd64;
        1: c = 7'($urandom_range(65, 127));
        2: c = 7'd1;
        default: c = 7'($urandom_range(2, 16));
      endcase
      set_count(c);
      if (phase >= 20) quiet_sender = 1'b1;
      queue_phase((c > 64) ? 64 : int'(c), 50);
    end
    drain();
    if (error_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
